// File: sv/mrld_pkg.sv
package mrld_pkg;

    localparam int MAX_SIDE_DEF = 2048;
    localparam int CFG_W        = 12;
    localparam int ROW_W        = 12;
    localparam int CFG_IDX_W    = 3;

    localparam logic [ROW_W-1:0] ROW_LIMIT = '1;

    localparam logic [7:0] CH_START   = 8'h50;  // 'P'
    localparam logic [7:0] CH_END     = 8'h4B;  // 'K'
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WALL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_END_X     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y     = 3'd7;

    typedef struct packed {
        logic [7:0] lead_byte;
        logic [7:0] symbol;
        logic [7:0] run_minus_one;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte_0;
        logic [7:0] out_byte_1;
        logic [7:0] out_byte_2;
        logic [7:0] out_byte_3;
        logic [7:0] out_byte_4;
        logic [7:0] out_byte_5;
        logic [7:0] out_byte_6;
        logic [7:0] out_byte_7;
        logic [3:0] byte_count;
        logic       last_group;
        logic       bad_codeword;
    } t_out_item;

    typedef struct packed {
        logic [7:0]       separator_byte;
        logic [7:0]       wall_byte;
        logic [7:0]       path_byte;
        logic [CFG_W-1:0] columns;
        logic [CFG_W-1:0] start_x;
        logic [CFG_W-1:0] start_y;
        logic [CFG_W-1:0] end_x;
        logic [CFG_W-1:0] end_y;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_byte_strm;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_NEWLINE,
        S_ERR
    } t_gen_state;

endpackage

// File: sv/mrld_char_gen.sv
module mrld_char_gen
    import mrld_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_in_valid,
    input  t_in_item   i_in_data,
    output logic       o_in_stall,
    output logic       o_byte_valid,
    output t_byte_strm o_byte,
    input  logic       i_byte_rdy
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int XW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

    t_gen_state       r_state, n_state;
    logic [CW-1:0]    r_pos, n_pos;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_err, n_err;
    logic [7:0]       r_sym, n_sym;
    logic [7:0]       r_rem, n_rem;
    logic             r_done, n_done;

    logic [XW-1:0] cols_eff;
    logic [XW-1:0] col1;
    logic          row_end;
    logic [7:0]    ch;
    logic          bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_row   <= ROW_W'(1);
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_row   <= n_row;
            r_err   <= n_err;
        end
        r_sym  <= n_sym;
        r_rem  <= n_rem;
        r_done <= n_done;
    end

    always_comb begin
        if (i_cfg.columns == '0 || XW'(i_cfg.columns) > XW'(MAX_SIDE)) begin
            cols_eff = XW'(MAX_SIDE);
        end else begin
            cols_eff = XW'(i_cfg.columns);
        end
        col1    = XW'(r_pos) + XW'(1);
        row_end = (col1 >= cols_eff);
        if (r_row == i_cfg.start_y && col1 == XW'(i_cfg.start_x)) begin
            ch = CH_START;
        end else if (r_row == i_cfg.end_y && col1 == XW'(i_cfg.end_x)) begin
            ch = CH_END;
        end else begin
            ch = r_sym;
        end
        bad = (i_in_data.lead_byte != i_cfg.separator_byte) ||
              (i_in_data.symbol != i_cfg.wall_byte && i_in_data.symbol != i_cfg.path_byte);

        n_state      = r_state;
        n_pos        = r_pos;
        n_row        = r_row;
        n_err        = r_err;
        n_sym        = r_sym;
        n_rem        = r_rem;
        n_done       = r_done;
        o_in_stall   = (r_state != S_IDLE);
        o_byte_valid = 1'b0;
        o_byte       = '{data: ch, last: 1'b0, err: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (r_err || bad) begin
                        n_err   = 1'b1;
                        n_state = S_ERR;
                    end else begin
                        n_sym   = i_in_data.symbol;
                        n_rem   = i_in_data.run_minus_one;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                o_byte_valid = 1'b1;
                o_byte.last  = (r_rem == '0) && !row_end;
                if (i_byte_rdy) begin
                    n_done = (r_rem == '0);
                    n_rem  = r_rem - 8'd1;
                    if (row_end) begin
                        n_pos   = '0;
                        n_state = S_NEWLINE;
                        if (r_row != ROW_LIMIT) begin
                            n_row = r_row + ROW_W'(1);
                        end
                    end else begin
                        n_pos = CW'(col1);
                        if (r_rem == '0) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_NEWLINE: begin
                o_byte_valid = 1'b1;
                o_byte.data  = CH_NEWLINE;
                o_byte.last  = r_done;
                if (i_byte_rdy) begin
                    n_state = r_done ? S_IDLE : S_RUN;
                end
            end
            S_ERR: begin
                o_byte_valid = 1'b1;
                o_byte       = '{data: 8'h00, last: 1'b1, err: 1'b1};
                if (i_byte_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/mrld_packer.sv
module mrld_packer
    import mrld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  t_byte_strm i_byte,
    output logic       o_byte_rdy,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  logic       i_out_stall
);

    logic [7:0] r_acc [8];
    logic [2:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;

    logic       take;
    logic       flush;
    logic [7:0] grp [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        if (take) begin
            r_acc[r_cnt] <= i_byte.data;
        end
        r_out <= n_out;
    end

    always_comb begin
        o_byte_rdy = !r_out_valid || !i_out_stall;
        take       = i_byte_valid && o_byte_rdy;
        flush      = take && (i_byte.err || i_byte.last || r_cnt == 3'd7);

        for (int k = 0; k < 8; k++) begin
            if (i_byte.err) begin
                grp[k] = 8'h00;
            end else if (3'(k) < r_cnt) begin
                grp[k] = r_acc[k];
            end else if (3'(k) == r_cnt) begin
                grp[k] = i_byte.data;
            end else begin
                grp[k] = 8'h00;
            end
        end

        n_cnt = r_cnt;
        if (flush) begin
            n_cnt = '0;
        end else if (take) begin
            n_cnt = r_cnt + 3'd1;
        end

        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (flush) begin
            n_out_valid             = 1'b1;
            n_out.out_byte_0        = grp[0];
            n_out.out_byte_1        = grp[1];
            n_out.out_byte_2        = grp[2];
            n_out.out_byte_3        = grp[3];
            n_out.out_byte_4        = grp[4];
            n_out.out_byte_5        = grp[5];
            n_out.out_byte_6        = grp[6];
            n_out.out_byte_7        = grp[7];
            n_out.byte_count        = i_byte.err ? 4'd0 : 4'(r_cnt) + 4'd1;
            n_out.last_group        = i_byte.err || i_byte.last;
            n_out.bad_codeword      = i_byte.err;
        end

        o_out_valid = r_out_valid;
        o_out_data  = r_out;
    end

endmodule

// File: sv/maze_run_length_decoder_top.sv
// Maze run-length decoder.
// Input channel (i_in_valid / o_in_stall, i_in_data): one codeword per item,
// lead byte, symbol and run count minus one. Output channel (o_out_valid /
// i_out_stall, o_out_data): groups of up to eight raster characters, the
// last group of a codeword flagged by last_group.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 separator, 1 wall, 2 path, 3 columns, 4/5 start x/y, 6/7 end x/y);
// write only while the block is idle.
// Timing: one character or newline is produced per cycle by a single
// character step while the output is not stalled. A bad codeword, or any
// codeword once in error, yields one error item. A codeword yields up to
// 512 bytes. A group is registered and appears in the cycle after its last
// byte is taken. o_in_stall is high while a codeword is being expanded or
// an error item is pending.
// A stalled output holds its item; the character step pauses until the
// output register frees.
// Reset (synchronous): registers return to defaults, position to row 1
// column 0, sticky error cleared, no output pending.
module maze_run_length_decoder_top
    import mrld_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output t_out_item            o_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg       r_cfg, n_cfg;
    logic       byte_valid;
    t_byte_strm byte_s;
    logic       byte_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{separator_byte: 8'h00, wall_byte: 8'h00, path_byte: 8'h00,
                       columns: CFG_W'(1), start_x: CFG_W'(1), start_y: CFG_W'(1),
                       end_x: CFG_W'(1), end_y: CFG_W'(1)};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SEPARATOR: n_cfg.separator_byte = i_cfg_data[7:0];
                REG_WALL:      n_cfg.wall_byte      = i_cfg_data[7:0];
                REG_PATH:      n_cfg.path_byte      = i_cfg_data[7:0];
                REG_COLUMNS:   n_cfg.columns        = i_cfg_data;
                REG_START_X:   n_cfg.start_x        = i_cfg_data;
                REG_START_Y:   n_cfg.start_y        = i_cfg_data;
                REG_END_X:     n_cfg.end_x          = i_cfg_data;
                REG_END_Y:     n_cfg.end_y          = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    mrld_char_gen #(
        .MAX_SIDE (MAX_SIDE)
    ) u_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .o_byte_valid (byte_valid),
        .o_byte       (byte_s),
        .i_byte_rdy   (byte_rdy)
    );

    mrld_packer u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_valid),
        .i_byte       (byte_s),
        .o_byte_rdy   (byte_rdy),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule

// File: sv/mrld_checker.sv
module mrld_checker
    import mrld_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output item changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output item after reset");

    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.bad_codeword |->
            o_out_data.byte_count == 4'd0 && o_out_data.last_group &&
            o_out_data.out_byte_0 == 8'h00)
        else $error("malformed error item");

    a_full_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.bad_codeword && !o_out_data.last_group |->
            o_out_data.byte_count == 4'd8)
        else $error("non-final group not full");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.bad_codeword |->
            o_out_data.byte_count != 4'd0 && o_out_data.byte_count <= 4'd8)
        else $error("group byte count out of range");

endmodule

bind maze_run_length_decoder_top mrld_checker u_mrld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
